// ----- design/ptq_pkg.sv -----
// Package for the promotable max-priority table: sizes, codes and item types.
package ptq_pkg;

  localparam int DEPTH         = 16;
  localparam int OBJECT_BITS   = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int IDX_BITS      = $clog2(DEPTH);
  localparam int ID_BITS       = 4;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_PROMOTE = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_PEEK    = 3'd3;
  localparam logic [2:0] OP_POP     = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BAD_ID = 2'd3;

  localparam logic [PRIORITY_BITS-1:0] PRI_MAX = '1;

  typedef struct packed {
    logic [2:0]             opcode;
    logic [OBJECT_BITS-1:0] object_value;
    logic [ID_BITS-1:0]     entry_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [ID_BITS-1:0]       result_id;
    logic [OBJECT_BITS-1:0]   out_object;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic                     id_valid;
  } out_item_t;

  typedef struct packed {
    logic exec;
    logic scan_init;
    logic scan_step;
    logic finish;
  } ptq_cmd_t;

  typedef struct packed {
    logic scan_op;
    logic scan_last;
  } ptq_sts_t;

endpackage

// ----- design/ptq_ctrl.sv -----
// Controller state machine for the promotable max-priority table.
module ptq_ctrl import ptq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ptq_sts_t sts,
  output ptq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.scan_op) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- design/ptq_dp.sv -----
// Datapath of the promotable max-priority table: slot storage, scan and result register.
module ptq_dp import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ptq_cmd_t  cmd,
  output ptq_sts_t  sts,
  input  in_item_t  in_item,
  output out_item_t out_item,
  output logic      out_valid
);

  logic [DEPTH-1:0]         valid_r, valid_nxt;
  logic [OBJECT_BITS-1:0]   obj_r [DEPTH];
  logic [OBJECT_BITS-1:0]   obj_nxt [DEPTH];
  logic [PRIORITY_BITS-1:0] pri_r [DEPTH];
  logic [PRIORITY_BITS-1:0] pri_nxt [DEPTH];
  logic [DEPTH-1:0]         newer_r [DEPTH];
  logic [DEPTH-1:0]         newer_nxt [DEPTH];

  logic [IDX_BITS-1:0]      idx_r, idx_nxt;
  logic [IDX_BITS-1:0]      best_r, best_nxt;
  logic                     found_r, found_nxt;
  logic [PRIORITY_BITS-1:0] best_pri_r, best_pri_nxt;
  logic [OBJECT_BITS-1:0]   best_obj_r, best_obj_nxt;
  logic                     pop_r, pop_nxt;
  out_item_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [IDX_BITS-1:0]      id_idx;
  logic                     id_ok;
  logic [IDX_BITS-1:0]      rd_idx;
  logic                     rd_valid;
  logic [OBJECT_BITS-1:0]   rd_obj;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [DEPTH-1:0]         rd_newer;
  logic                     free_found;
  logic [IDX_BITS-1:0]      free_idx;
  logic                     take;

  assign id_idx = IDX_BITS'(in_item.entry_id);
  assign rd_idx = cmd.scan_step ? idx_r : id_idx;

  assign rd_valid = valid_r[rd_idx];
  assign rd_obj   = obj_r[rd_idx];
  assign rd_pri   = pri_r[rd_idx];
  assign rd_newer = newer_r[rd_idx];

  assign id_ok = ((32'(in_item.entry_id)) < DEPTH) && rd_valid;

  assign sts.scan_op   = (in_item.opcode == OP_PEEK) || (in_item.opcode == OP_POP);
  assign sts.scan_last = (idx_r == IDX_BITS'(DEPTH - 1));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_BITS'(i);
      end
    end
  end

  assign take = rd_valid && (!found_r || (rd_pri > best_pri_r) ||
                ((rd_pri == best_pri_r) && rd_newer[best_r]));

  always_comb begin
    valid_nxt     = valid_r;
    obj_nxt       = obj_r;
    pri_nxt       = pri_r;
    newer_nxt     = newer_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    best_pri_nxt  = best_pri_r;
    best_obj_nxt  = best_obj_r;
    pop_nxt       = pop_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    if (cmd.exec) begin
      out_nxt       = '0;
      out_valid_nxt = 1'b1;
      priority if (in_item.opcode == OP_ADD) begin
        if (!free_found) begin
          out_nxt.status = ST_FULL;
        end else begin
          valid_nxt[free_idx] = 1'b1;
          obj_nxt[free_idx]   = in_item.object_value;
          pri_nxt[free_idx]   = '0;
          for (int i = 0; i < DEPTH; i++) begin
            newer_nxt[i][free_idx] = 1'b0;
            if (IDX_BITS'(i) != free_idx) begin
              newer_nxt[free_idx][i] = 1'b1;
            end
          end
          out_nxt.result_id = ID_BITS'(free_idx);
          out_nxt.id_valid  = 1'b1;
        end
      end else if ((in_item.opcode == OP_PROMOTE) || (in_item.opcode == OP_READ)) begin
        if (!id_ok) begin
          out_nxt.status = ST_BAD_ID;
        end else begin
          out_nxt.id_valid = 1'b1;
          if (in_item.opcode == OP_PROMOTE) begin
            if (rd_pri != PRI_MAX) begin
              pri_nxt[id_idx] = rd_pri + 1'b1;
            end
          end else begin
            out_nxt.out_object = rd_obj;
          end
        end
      end else begin
        out_nxt = '0;
      end
    end

    if (cmd.scan_init) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
      best_nxt  = '0;
      pop_nxt   = (in_item.opcode == OP_POP);
    end

    if (cmd.scan_step) begin
      idx_nxt = idx_r + 1'b1;
      if (take) begin
        found_nxt    = 1'b1;
        best_nxt     = idx_r;
        best_pri_nxt = rd_pri;
        best_obj_nxt = rd_obj;
      end
    end

    if (cmd.finish) begin
      out_nxt       = '0;
      out_valid_nxt = 1'b1;
      if (!found_r) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        out_nxt.result_id    = ID_BITS'(best_r);
        out_nxt.out_object   = best_obj_r;
        out_nxt.out_priority = best_pri_r;
        out_nxt.id_valid     = 1'b1;
        if (pop_r) begin
          valid_nxt[best_r] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obj_r      <= obj_nxt;
    pri_r      <= pri_nxt;
    newer_r    <= newer_nxt;
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    best_pri_r <= best_pri_nxt;
    best_obj_r <= best_obj_nxt;
    pop_r      <= pop_nxt;
    out_r      <= out_nxt;
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

// ----- design/promotable_max_priority_table.sv -----
// Top level of the promotable max-priority table: controller plus datapath.
//
// Usage:
//   An item is taken on in_item at a rising edge where start is high and busy
//   is low. Every item gives exactly one result on out_item, shown for one
//   cycle with out_valid high; the receiver cannot stall it.
//   Add, promote, read and unused opcodes complete in the accept cycle: the
//   result appears in the next cycle and busy stays low, so one such item can
//   be accepted every cycle.
//   Peek and pop walk the sixteen slots one per cycle with a single compare
//   unit, then register the result (and free the popped slot). Busy stays
//   high through the scan and the finish state; the result is shown in the
//   first cycle with busy low, and the next item may be accepted at the edge
//   that ends that cycle.
//   Ties on priority go to the most recently added slot.
//   Reset (rst_n low, synchronous) empties the table, returns the controller
//   to idle and drops out_valid.
module promotable_max_priority_table import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ptq_cmd_t cmd;
  ptq_sts_t sts;

  ptq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ptq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

endmodule
